// File: hdl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants for the reflectance line classifier.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int TIME_BITS    = 14;
  localparam int DRIVE_BITS   = 16;
  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;
  localparam int REG_IDX_W    = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CRUISE_LEFT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CRUISE_RIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TRIM_STEP    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_LEFT    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_RIGHT   = 3'd7;

  // Sensor positions, 0-based (sensor n sits at n-1)
  localparam int S2 = 1;
  localparam int S3 = 2;
  localparam int S4 = 3;
  localparam int S5 = 4;
  localparam int S6 = 5;
  localparam int S7 = 6;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [DRIVE_BITS-1:0] drive_t;

  typedef enum logic [3:0] {
    DEC_CROSS       = 4'd0,
    DEC_RIGHT       = 4'd1,
    DEC_LEFT        = 4'd2,
    DEC_BACK        = 4'd3,
    DEC_PIVOT_RIGHT = 4'd4,
    DEC_PIVOT_LEFT  = 4'd5,
    DEC_TRIM_LEFT   = 4'd6,
    DEC_TRIM_RIGHT  = 4'd7,
    DEC_STRAIGHT    = 4'd8
  } decision_t;

  typedef struct packed {
    logic [SENSOR_COUNT-1:0] sensor_bits;
    logic                    window_start;
  } rlc_in_t;

  typedef struct packed {
    logic [3:0] decision;
    drive_t     left_drive;
    drive_t     right_drive;
    logic       front_line;
  } rlc_out_t;

  typedef struct packed {
    time_t  window_low;
    time_t  window_high;
    time_t  sample_count;
    drive_t cruise_left;
    drive_t cruise_right;
    drive_t trim_step;
    drive_t spin_left_drive;
    drive_t spin_right_drive;
  } rlc_cfg_t;

  // Per-lane classification of one capture time
  typedef struct packed {
    logic in_win;
    logic below;
  } lane_flag_t;

endpackage

// File: hdl/rlc_cfg.sv
// ----------------------------------------------------------------------------
// rlc_cfg
// APB register bank holding the classifier configuration.
// ----------------------------------------------------------------------------
module rlc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rlc_pkg::APB_AW-1:0] paddr,
  input  logic [rlc_pkg::APB_DW-1:0] pwdata,
  output logic [rlc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output rlc_pkg::rlc_cfg_t          cfg
);

  logic                              wr_en;
  logic [rlc_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[rlc_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_low       <= rlc_pkg::TIME_BITS'(400);
      cfg.window_high      <= rlc_pkg::TIME_BITS'(1300);
      cfg.sample_count     <= rlc_pkg::TIME_BITS'(10000);
      cfg.cruise_left      <= '0;
      cfg.cruise_right     <= '0;
      cfg.trim_step        <= rlc_pkg::DRIVE_BITS'(200);
      cfg.spin_left_drive  <= rlc_pkg::DRIVE_BITS'(1080);
      cfg.spin_right_drive <= rlc_pkg::DRIVE_BITS'(1000);
    end else if (wr_en) begin
      unique case (idx)
        rlc_pkg::REG_WINDOW_LOW:   cfg.window_low       <= pwdata[rlc_pkg::TIME_BITS-1:0];
        rlc_pkg::REG_WINDOW_HIGH:  cfg.window_high      <= pwdata[rlc_pkg::TIME_BITS-1:0];
        rlc_pkg::REG_SAMPLE_COUNT: cfg.sample_count     <= pwdata[rlc_pkg::TIME_BITS-1:0];
        rlc_pkg::REG_CRUISE_LEFT:  cfg.cruise_left      <= pwdata[rlc_pkg::DRIVE_BITS-1:0];
        rlc_pkg::REG_CRUISE_RIGHT: cfg.cruise_right     <= pwdata[rlc_pkg::DRIVE_BITS-1:0];
        rlc_pkg::REG_TRIM_STEP:    cfg.trim_step        <= pwdata[rlc_pkg::DRIVE_BITS-1:0];
        rlc_pkg::REG_SPIN_LEFT:    cfg.spin_left_drive  <= pwdata[rlc_pkg::DRIVE_BITS-1:0];
        rlc_pkg::REG_SPIN_RIGHT:   cfg.spin_right_drive <= pwdata[rlc_pkg::DRIVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rlc_pkg::REG_WINDOW_LOW:   prdata = rlc_pkg::APB_DW'(cfg.window_low);
      rlc_pkg::REG_WINDOW_HIGH:  prdata = rlc_pkg::APB_DW'(cfg.window_high);
      rlc_pkg::REG_SAMPLE_COUNT: prdata = rlc_pkg::APB_DW'(cfg.sample_count);
      rlc_pkg::REG_CRUISE_LEFT:  prdata = rlc_pkg::APB_DW'(cfg.cruise_left);
      rlc_pkg::REG_CRUISE_RIGHT: prdata = rlc_pkg::APB_DW'(cfg.cruise_right);
      rlc_pkg::REG_TRIM_STEP:    prdata = rlc_pkg::APB_DW'(cfg.trim_step);
      rlc_pkg::REG_SPIN_LEFT:    prdata = rlc_pkg::APB_DW'(cfg.spin_left_drive);
      rlc_pkg::REG_SPIN_RIGHT:   prdata = rlc_pkg::APB_DW'(cfg.spin_right_drive);
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: hdl/rlc_lane.sv
// ----------------------------------------------------------------------------
// rlc_lane
// One sensor lane: first-low capture register and window classification.
// ----------------------------------------------------------------------------
module rlc_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 start,
  input  logic                 window_end,
  input  logic                 sensor_bit,
  input  rlc_pkg::time_t       tick_now,
  input  rlc_pkg::time_t       window_low,
  input  rlc_pkg::time_t       window_high,
  output rlc_pkg::lane_flag_t  flag
);

  rlc_pkg::time_t capture;
  rlc_pkg::time_t capture_cur;
  rlc_pkg::time_t capture_next;

  always_comb begin
    capture_cur  = start ? '0 : capture;
    // a zero capture still counts as unseen, so a later low overwrites it
    capture_next = (capture_cur == '0 && !sensor_bit) ? tick_now : capture_cur;
    flag.in_win  = (capture_next > window_low) && (capture_next < window_high);
    flag.below   = capture_next < window_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture <= '0;
    end else if (accept) begin
      capture <= window_end ? '0 : capture_next;
    end
  end

endmodule

// File: hdl/rlc_merge.sv
// ----------------------------------------------------------------------------
// rlc_merge
// Merge stage: registers the lane flags at window end, resolves the
// priority decision and drive values, and holds the result for the sink.
// ----------------------------------------------------------------------------
module rlc_merge (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       load,
  input  rlc_pkg::lane_flag_t [rlc_pkg::SENSOR_COUNT-1:0] flags,
  input  rlc_pkg::rlc_cfg_t                          cfg,
  output logic                                       hold,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output rlc_pkg::rlc_out_t                          out_item
);

  logic [rlc_pkg::SENSOR_COUNT-1:0] fl_in;
  logic [rlc_pkg::SENSOR_COUNT-1:0] fl_below;
  logic                             fl_valid;
  logic                             fl_move;
  rlc_pkg::rlc_out_t                result;
  rlc_pkg::decision_t               dec;

  assign fl_move = !out_valid || !out_stall;
  assign hold    = fl_valid && !fl_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_valid <= 1'b0;
    end else if (load) begin
      fl_valid <= 1'b1;
    end else if (fl_move) begin
      fl_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < rlc_pkg::SENSOR_COUNT; k++) begin
        fl_in[k]    <= flags[k].in_win;
        fl_below[k] <= flags[k].below;
      end
    end
  end

  always_comb begin
    priority if (fl_in[rlc_pkg::S2] && fl_in[rlc_pkg::S7]) begin
      dec = rlc_pkg::DEC_CROSS;
    end else if (fl_in[rlc_pkg::S2] && fl_in[rlc_pkg::S3]) begin
      dec = rlc_pkg::DEC_RIGHT;
    end else if (fl_in[rlc_pkg::S7] && fl_in[rlc_pkg::S6]) begin
      dec = rlc_pkg::DEC_LEFT;
    end else if (fl_below[rlc_pkg::S5] && fl_below[rlc_pkg::S4]) begin
      dec = rlc_pkg::DEC_BACK;
    end else if (fl_in[rlc_pkg::S2]) begin
      dec = rlc_pkg::DEC_PIVOT_RIGHT;
    end else if (fl_in[rlc_pkg::S7]) begin
      dec = rlc_pkg::DEC_PIVOT_LEFT;
    end else if (fl_in[rlc_pkg::S3]) begin
      dec = rlc_pkg::DEC_TRIM_LEFT;
    end else if (fl_in[rlc_pkg::S6]) begin
      dec = rlc_pkg::DEC_TRIM_RIGHT;
    end else begin
      dec = rlc_pkg::DEC_STRAIGHT;
    end
  end

  always_comb begin
    result.decision   = dec;
    result.front_line = fl_in[rlc_pkg::S4] && fl_in[rlc_pkg::S5];
    unique case (dec)
      rlc_pkg::DEC_PIVOT_RIGHT, rlc_pkg::DEC_PIVOT_LEFT: begin
        result.left_drive  = cfg.spin_left_drive;
        result.right_drive = cfg.spin_right_drive;
      end
      rlc_pkg::DEC_TRIM_LEFT: begin
        result.left_drive  = (cfg.cruise_left > cfg.trim_step) ?
                             cfg.cruise_left - cfg.trim_step : '0;
        result.right_drive = cfg.cruise_right;
      end
      rlc_pkg::DEC_TRIM_RIGHT: begin
        result.left_drive  = cfg.cruise_left;
        result.right_drive = (cfg.cruise_right > cfg.trim_step) ?
                             cfg.cruise_right - cfg.trim_step : '0;
      end
      rlc_pkg::DEC_STRAIGHT: begin
        result.left_drive  = cfg.cruise_left;
        result.right_drive = cfg.cruise_right;
      end
      default: begin
        result.left_drive  = '0;
        result.right_drive = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fl_move) begin
      out_valid <= fl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_move && fl_valid) begin
      out_item <= result;
    end
  end

endmodule

// File: hdl/reflectance_line_classifier.sv
// ----------------------------------------------------------------------------
// reflectance_line_classifier
// Top level: tick counter, eight capture lanes, merge stage and APB registers.
// ----------------------------------------------------------------------------
// Takes one sensor sample per cycle; the eight lanes update their first-low
// capture times in parallel, so a new request is accepted every cycle while
// in_stall is low. On the last tick of a window the lane flags are registered
// in the merge stage, then the result in the output register. Input stall
// rises only while a result sits there and the output register is stalled.
module reflectance_line_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rlc_pkg::rlc_in_t           in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rlc_pkg::rlc_out_t          out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rlc_pkg::APB_AW-1:0] paddr,
  input  logic [rlc_pkg::APB_DW-1:0] pwdata,
  output logic [rlc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  rlc_pkg::rlc_cfg_t                              cfg;
  rlc_pkg::lane_flag_t [rlc_pkg::SENSOR_COUNT-1:0] flags;
  rlc_pkg::time_t                                 tick;
  rlc_pkg::time_t                                 tick_now;
  rlc_pkg::time_t                                 last_tick;
  logic                                           accept;
  logic                                           window_end;
  logic                                           hold;

  assign in_stall   = hold;
  assign accept     = in_valid && !in_stall;
  assign tick_now   = in_item.window_start ? '0 : tick;
  assign last_tick  = (cfg.sample_count == '0) ? '0 : cfg.sample_count - 1'b1;
  assign window_end = tick_now >= last_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (accept) begin
      tick <= window_end ? '0 : tick_now + 1'b1;
    end
  end

  rlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar k = 0; k < rlc_pkg::SENSOR_COUNT; k++) begin : g_lane
    rlc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .accept      (accept),
      .start       (in_item.window_start),
      .window_end  (window_end),
      .sensor_bit  (in_item.sensor_bits[k]),
      .tick_now    (tick_now),
      .window_low  (cfg.window_low),
      .window_high (cfg.window_high),
      .flag        (flags[k])
    );
  end

  rlc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && window_end),
    .flags     (flags),
    .cfg       (cfg),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the reflectance line classifier. Sensor sample requests go in
// from a queue in random bursts while the result side stalls on its own
// pattern. A local predictor tracks the tick counter and the capture times,
// and every result is checked field by field. Registers are set over APB only
// while the block is drained, and each write is read back.
// ----------------------------------------------------------------------------
module tb;
  import rlc_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_REPORTS  = 10;
  localparam int TIME_MAX     = 16383;
  localparam int DRIVE_MAX    = 65535;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rlc_in_t           in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rlc_out_t          out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  reflectance_line_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: register copy, tick counter and per-sensor capture times
  rlc_cfg_t  cfg_m = '{window_low: 400, window_high: 1300, sample_count: 10000,
                       cruise_left: 0, cruise_right: 0, trim_step: 200,
                       spin_left_drive: 1080, spin_right_drive: 1000};
  time_t     tick_m = '0;
  time_t     first_low_m [SENSOR_COUNT] = '{default: '0};

  rlc_in_t   pending_req [$];
  rlc_out_t  expected_result [$];
  int        queued_cnt = 0;
  int        accepted_cnt = 0;
  int        mismatch_cnt = 0;
  bit        req_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_run = 0;
  int        free_run = 0;

  initial forever #5 clk = ~clk;

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic bit lane_in_window(int pos);
    return first_low_m[pos] > cfg_m.window_low && first_low_m[pos] < cfg_m.window_high;
  endfunction

  function automatic drive_t trimmed(drive_t base, drive_t step);
    return (base > step) ? drive_t'(base - step) : '0;
  endfunction

  // Advance the predictor by one sample; return 1 when the window closes.
  function automatic bit classify_sample(rlc_in_t req, output rlc_out_t res);
    time_t     last_tick;
    decision_t dec;
    drive_t    ld;
    drive_t    rd;
    int        k;
    res = '0;
    if (req.window_start) begin
      tick_m = '0;
      for (k = 0; k < SENSOR_COUNT; k++) first_low_m[k] = '0;
    end
    for (k = 0; k < SENSOR_COUNT; k++)
      if (first_low_m[k] == '0 && !req.sensor_bits[k]) first_low_m[k] = tick_m;
    last_tick = (cfg_m.sample_count == '0) ? '0 : time_t'(cfg_m.sample_count - 1'b1);
    if (tick_m < last_tick) begin
      tick_m = time_t'(tick_m + 1'b1);
      return 1'b0;
    end
    ld = '0;
    rd = '0;
    if (lane_in_window(S2) && lane_in_window(S7)) begin
      dec = DEC_CROSS;
    end else if (lane_in_window(S2) && lane_in_window(S3)) begin
      dec = DEC_RIGHT;
    end else if (lane_in_window(S7) && lane_in_window(S6)) begin
      dec = DEC_LEFT;
    end else if (first_low_m[S5] < cfg_m.window_low && first_low_m[S4] < cfg_m.window_low) begin
      dec = DEC_BACK;
    end else if (lane_in_window(S2)) begin
      dec = DEC_PIVOT_RIGHT;
      ld = cfg_m.spin_left_drive;
      rd = cfg_m.spin_right_drive;
    end else if (lane_in_window(S7)) begin
      dec = DEC_PIVOT_LEFT;
      ld = cfg_m.spin_left_drive;
      rd = cfg_m.spin_right_drive;
    end else if (lane_in_window(S3)) begin
      dec = DEC_TRIM_LEFT;
      ld = trimmed(cfg_m.cruise_left, cfg_m.trim_step);
      rd = cfg_m.cruise_right;
    end else if (lane_in_window(S6)) begin
      dec = DEC_TRIM_RIGHT;
      ld = cfg_m.cruise_left;
      rd = trimmed(cfg_m.cruise_right, cfg_m.trim_step);
    end else begin
      dec = DEC_STRAIGHT;
      ld = cfg_m.cruise_left;
      rd = cfg_m.cruise_right;
    end
    res.decision    = dec;
    res.left_drive  = ld;
    res.right_drive = rd;
    res.front_line  = lane_in_window(S4) && lane_in_window(S5);
    tick_m = '0;
    for (k = 0; k < SENSOR_COUNT; k++) first_low_m[k] = '0;
    return 1'b1;
  endfunction

  // Sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_req.size() != 0) begin
        in_valid <= 1'b1;
        in_item  <= pending_req.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall runs between free runs, now and then a long free stretch
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run--;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        free_run  = $urandom_range(20, 60);
        stall_run = 0;
      end else begin
        free_run  = $urandom_range(0, 5);
        stall_run = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    rlc_out_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_stall === 1'b0;
      if (in_valid && in_stall === 1'b0) begin
        accepted_cnt++;
        if (classify_sample(in_item, want)) expected_result.push_back(want);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_result.size() == 0) begin
          note_mismatch($sformatf("unexpected result dec %0d left %0d right %0d front %0b",
                                  out_item.decision, out_item.left_drive,
                                  out_item.right_drive, out_item.front_line));
        end else begin
          want = expected_result.pop_front();
          if (out_item.decision !== want.decision || out_item.left_drive !== want.left_drive ||
              out_item.right_drive !== want.right_drive ||
              out_item.front_line !== want.front_line)
            note_mismatch($sformatf(
              "exp dec %0d left %0d right %0d front %0b, got dec %0d left %0d right %0d front %0b",
              want.decision, want.left_drive, want.right_drive, want.front_line,
              out_item.decision, out_item.left_drive, out_item.right_drive,
              out_item.front_line));
        end
      end
    end
  end

  task automatic push_req(logic [SENSOR_COUNT-1:0] bits, logic start);
    rlc_in_t r;
    r.sensor_bits  = bits;
    r.window_start = start;
    pending_req.push_back(r);
    queued_cnt++;
  endtask

  // Hold until every request is taken and every result has come, then idle.
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_result.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write then read back; call at a falling edge with the block drained.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
    logic [APB_DW-1:0] got;
    int unsigned       kept;
    kept = (idx <= REG_SAMPLE_COUNT) ? (value & TIME_MAX) : (value & DRIVE_MAX);
    case (idx)
      REG_WINDOW_LOW:   cfg_m.window_low       = kept;
      REG_WINDOW_HIGH:  cfg_m.window_high      = kept;
      REG_SAMPLE_COUNT: cfg_m.sample_count     = kept;
      REG_CRUISE_LEFT:  cfg_m.cruise_left      = kept;
      REG_CRUISE_RIGHT: cfg_m.cruise_right     = kept;
      REG_TRIM_STEP:    cfg_m.trim_step        = kept;
      REG_SPIN_LEFT:    cfg_m.spin_left_drive  = kept;
      REG_SPIN_RIGHT:   cfg_m.spin_right_drive = kept;
      default: ;
    endcase
    paddr   = {idx, 2'b00};
    pwdata  = kept;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== APB_DW'(kept))
      note_mismatch($sformatf("register %0d read %0h, wrote %0h", idx, got, kept));
  endtask

  // Queue one window: each sensor drops at most once and stays low, with optional flips.
  task automatic push_window(int len, int lo, int hi, int noise_pct);
    int                      drop_at [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] bits;
    int                      k;
    int                      t;
    int                      top;
    for (k = 0; k < SENSOR_COUNT; k++) begin
      top = (hi - 1 < len - 1) ? hi - 1 : len - 1;
      case ($urandom_range(0, 7))
        0: drop_at[k] = len;
        1: drop_at[k] = 0;
        2: drop_at[k] = $urandom_range(0, lo);
        3: drop_at[k] = $urandom_range(hi, hi + 4);
        default: drop_at[k] = (lo + 1 <= top) ? $urandom_range(lo + 1, top)
                                             : $urandom_range(0, len - 1);
      endcase
    end
    for (t = 0; t < len; t++) begin
      for (k = 0; k < SENSOR_COUNT; k++) bits[k] = (t >= drop_at[k]) ? 1'b0 : 1'b1;
      if ($urandom_range(0, 99) < noise_pct) bits[$urandom_range(0, SENSOR_COUNT - 1)] ^= 1'b1;
      push_req(bits, t == 0);
    end
  endtask

  function automatic int unsigned pick_drive();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return DRIVE_MAX;
      default: return $urandom_range(0, DRIVE_MAX);
    endcase
  endfunction

  task automatic random_setting(output int sc, output int lo, output int hi);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) sc = 0;
    else if (pick <= 2) sc = 1;
    else if (pick <= 16) sc = $urandom_range(2, 40);
    else sc = $urandom_range(41, 300);
    lo = $urandom_range(0, sc);
    hi = lo + $urandom_range(2, sc + 2);
    pick = $urandom_range(0, 19);
    if (pick == 0) hi = $urandom_range(0, lo);
    else if (pick == 1) lo = 0;
    else if (pick == 2) hi = TIME_MAX;
    else if (pick == 3) lo = TIME_MAX;
    else if (pick == 4) hi = 0;
    if (hi > TIME_MAX) hi = TIME_MAX;
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    write_reg(REG_SAMPLE_COUNT, sc);
    write_reg(REG_CRUISE_LEFT, pick_drive());
    write_reg(REG_CRUISE_RIGHT, pick_drive());
    write_reg(REG_TRIM_STEP, pick_drive());
    write_reg(REG_SPIN_LEFT, pick_drive());
    write_reg(REG_SPIN_RIGHT, pick_drive());
  endtask

  initial begin
    int sc;
    int lo;
    int hi;
    int len;
    int n_win;
    int w;
    int k;
    int rand_base;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_WINDOW_LOW, 2);
    write_reg(REG_WINDOW_HIGH, 6);
    write_reg(REG_SAMPLE_COUNT, 8);
    write_reg(REG_CRUISE_LEFT, DRIVE_MAX);
    write_reg(REG_CRUISE_RIGHT, 0);
    write_reg(REG_TRIM_STEP, DRIVE_MAX);
    write_reg(REG_SPIN_LEFT, 0);
    write_reg(REG_SPIN_RIGHT, DRIVE_MAX);
    // all low at tick 0 counts as unseen; later lows overwrite, sensors 1 and 8 ignored
    push_req(8'h00, 1'b1);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hBD, 1'b0);
    push_req(8'h7E, 1'b0);
    push_req(8'hE7, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b0);
    // cut a window short with a new start, then trim with full saturation
    for (k = 0; k < 3; k++) push_req(8'hFF, k == 0);
    push_req(8'hFF, 1'b1);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hFB, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'hEF, 1'b0);
    // lower the sample count while a window is open
    for (k = 0; k < 5; k++) push_req(8'hFF, k == 0);
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, 3);
    push_req(8'hFF, 1'b0);
    wait_drained();
    // zero sample count with an inverted window: every tick ends a window
    write_reg(REG_SAMPLE_COUNT, 0);
    write_reg(REG_WINDOW_LOW, 6);
    write_reg(REG_WINDOW_HIGH, 2);
    push_req(8'hFF, 1'b1);
    push_req(8'h00, 1'b0);
    wait_drained();

    rand_base = queued_cnt;
    while (queued_cnt - rand_base < RANDOM_ITEMS) begin
      random_setting(sc, lo, hi);
      n_win = $urandom_range(1, (sc < 8) ? 20 : 6);
      for (w = 0; w < n_win; w++) begin
        if ($urandom_range(0, 9) == 0)
          for (k = $urandom_range(1, 12); k > 0; k--)
            push_req($urandom_range(0, 255), $urandom_range(0, 7) == 0);
        len = (sc == 0) ? 1 : sc;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        push_window(len, lo, hi, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10));
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/rlc_pkg.sv
hdl/rlc_cfg.sv
hdl/rlc_lane.sv
hdl/rlc_merge.sv
hdl/reflectance_line_classifier.sv
sim/tb.sv
